/* hw/rtl/ppgb_pkg.sv */
// shared constants, types and helpers for the projection profile bounds block
`timescale 1ns / 1ps

package ppgb_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;

  // configuration register width, also wide enough for any dark count
  localparam int unsigned SizeW = 11;
  localparam int unsigned ColW  = $clog2(MaxWidth);
  localparam int unsigned RowW  = $clog2(MaxHeight);
  // width of 5*count against 2*size compares
  localparam int unsigned ThrW  = SizeW + 3;

  localparam int unsigned DarkLimit = 500;
  localparam int unsigned SumW      = 10;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  // register indexes on the configuration port
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  // one classified pixel on its way to the column store
  typedef struct packed {
    logic [ColW-1:0] x;
    logic            first_row;
    logic            dark;
    logic            frame_end;
    logic [RowW-1:0] top_row;
    logic [RowW-1:0] row_span;
    logic            rows_found;
  } work_t;

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v,
                                                  input logic [SizeW-1:0] lim);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) begin
      r = SizeW'(1);
    end else if (v > lim) begin
      r = lim;
    end
    return r;
  endfunction

  // 5 * cnt > 2 * size
  function automatic logic over_threshold(input logic [SizeW-1:0] cnt,
                                          input logic [SizeW-1:0] size);
    logic [ThrW-1:0] five_cnt;
    logic [ThrW-1:0] two_size;
    five_cnt = ThrW'({cnt, 2'b00}) + ThrW'(cnt);
    two_size = ThrW'({size, 1'b0});
    return five_cnt > two_size;
  endfunction

endpackage

/* hw/rtl/ppgb_if.sv */
// pixel and result channel interfaces
`timescale 1ns / 1ps

interface ppgb_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface ppgb_result_if;
  logic       valid;
  logic       ready;
  logic [9:0] left_col;
  logic [9:0] col_span;
  logic [9:0] top_row;
  logic [9:0] row_span;
  logic       cols_found;
  logic       rows_found;

  modport source (output valid, output left_col, output col_span, output top_row,
                  output row_span, output cols_found, output rows_found, input ready);
  modport sink   (input valid, input left_col, input col_span, input top_row,
                  input row_span, input cols_found, input rows_found, output ready);
endinterface

/* hw/rtl/ppgb_front.sv */
// front end: pixel classification, raster position and row profile
`timescale 1ns / 1ps

module ppgb_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [ppgb_pkg::SizeW-1:0]        width_i,
  input  logic [ppgb_pkg::SizeW-1:0]        height_i,
  ppgb_pixel_if.sink                        pixel_i,
  output logic                              push_valid_o,
  input  logic                              push_ready_i,
  output ppgb_pkg::work_t                   push_data_o
);

  logic [ppgb_pkg::SizeW-1:0] w;
  logic [ppgb_pkg::SizeW-1:0] h;
  logic [ppgb_pkg::SumW-1:0]  sum;
  logic                       dark;
  logic                       accept;

  logic [ppgb_pkg::ColW-1:0]  x_q, x_d;
  logic [ppgb_pkg::RowW-1:0]  y_q, y_d;
  logic [ppgb_pkg::SizeW-1:0] row_cnt_q, row_cnt_d;
  logic [ppgb_pkg::RowW-1:0]  first_q, first_d;
  logic [ppgb_pkg::RowW-1:0]  last_q, last_d;
  logic                       any_q, any_d;

  logic [ppgb_pkg::SizeW-1:0] row_cnt_now;
  logic                       row_end;
  logic                       frame_end;
  logic                       row_good;
  logic [ppgb_pkg::RowW-1:0]  new_first;
  logic [ppgb_pkg::RowW-1:0]  new_last;
  logic                       new_any;

  assign w = ppgb_pkg::clamp_size(width_i, ppgb_pkg::SizeW'(ppgb_pkg::MaxWidth));
  assign h = ppgb_pkg::clamp_size(height_i, ppgb_pkg::SizeW'(ppgb_pkg::MaxHeight));

  assign sum  = ppgb_pkg::SumW'(pixel_i.red) + ppgb_pkg::SumW'(pixel_i.green)
              + ppgb_pkg::SumW'(pixel_i.blue);
  assign dark = sum < ppgb_pkg::SumW'(ppgb_pkg::DarkLimit);

  assign pixel_i.ready = push_ready_i;
  assign accept        = pixel_i.valid && push_ready_i;

  assign row_cnt_now = row_cnt_q + ppgb_pkg::SizeW'(dark);
  assign row_end     = (ppgb_pkg::SizeW'(x_q) + ppgb_pkg::SizeW'(1)) >= w;
  assign frame_end   = row_end && ((ppgb_pkg::SizeW'(y_q) + ppgb_pkg::SizeW'(1)) >= h);
  assign row_good    = row_end && ppgb_pkg::over_threshold(row_cnt_now, h);

  assign new_any   = any_q || row_good;
  assign new_first = (row_good && !any_q) ? y_q : first_q;
  assign new_last  = row_good ? y_q : last_q;

  assign push_valid_o           = pixel_i.valid;
  assign push_data_o.x          = x_q;
  assign push_data_o.first_row  = (y_q == '0);
  assign push_data_o.dark       = dark;
  assign push_data_o.frame_end  = frame_end;
  assign push_data_o.top_row    = new_first;
  assign push_data_o.row_span   = new_last - new_first;
  assign push_data_o.rows_found = new_any;

  always_comb begin
    x_d       = x_q;
    y_d       = y_q;
    row_cnt_d = row_cnt_q;
    first_d   = first_q;
    last_d    = last_q;
    any_d     = any_q;
    if (accept) begin
      if (!row_end) begin
        x_d       = x_q + ppgb_pkg::ColW'(1);
        row_cnt_d = row_cnt_now;
      end else if (!frame_end) begin
        x_d       = '0;
        y_d       = y_q + ppgb_pkg::RowW'(1);
        row_cnt_d = '0;
        first_d   = new_first;
        last_d    = new_last;
        any_d     = new_any;
      end else begin
        x_d       = '0;
        y_d       = '0;
        row_cnt_d = '0;
        first_d   = '0;
        last_d    = '0;
        any_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q       <= '0;
      y_q       <= '0;
      row_cnt_q <= '0;
      first_q   <= '0;
      last_q    <= '0;
      any_q     <= 1'b0;
    end else begin
      x_q       <= x_d;
      y_q       <= y_d;
      row_cnt_q <= row_cnt_d;
      first_q   <= first_d;
      last_q    <= last_d;
      any_q     <= any_d;
    end
  end

endmodule

/* hw/rtl/ppgb_queue.sv */
// small fifo of classified pixels between front and back end
`timescale 1ns / 1ps

module ppgb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  ppgb_pkg::work_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output ppgb_pkg::work_t pop_data_o
);

  ppgb_pkg::work_t entries_q [ppgb_pkg::QueueDepth];

  logic [ppgb_pkg::QueueAw:0] wr_ptr_q, wr_ptr_d;
  logic [ppgb_pkg::QueueAw:0] rd_ptr_q, rd_ptr_d;
  logic                       full;
  logic                       empty;
  logic                       push;
  logic                       pop;

  assign empty = (wr_ptr_q == rd_ptr_q);
  assign full  = (wr_ptr_q[ppgb_pkg::QueueAw] != rd_ptr_q[ppgb_pkg::QueueAw])
              && (wr_ptr_q[ppgb_pkg::QueueAw-1:0] == rd_ptr_q[ppgb_pkg::QueueAw-1:0]);

  assign push_ready_o = !full;
  assign pop_valid_o  = !empty;
  assign pop_data_o   = entries_q[rd_ptr_q[ppgb_pkg::QueueAw-1:0]];

  assign push = push_valid_i && !full;
  assign pop  = pop_ready_i && !empty;

  assign wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q[ppgb_pkg::QueueAw-1:0]] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

endmodule

/* hw/rtl/ppgb_back.sv */
// back end: column count store, end of frame column scan and result register
`timescale 1ns / 1ps

module ppgb_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ppgb_pkg::SizeW-1:0] width_i,
  input  logic                       pop_valid_i,
  output logic                       pop_ready_o,
  input  ppgb_pkg::work_t            pop_data_i,
  ppgb_result_if.source              result_o
);

  localparam logic [1:0] StRun  = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [ppgb_pkg::SizeW-1:0] col_mem [ppgb_pkg::MaxWidth];
  logic [ppgb_pkg::SizeW-1:0] rdata_q;

  logic [1:0] state_q, state_d;
  logic       eof_pend_q, eof_pend_d;

  // update stage
  logic                       a_vld_q;
  ppgb_pkg::work_t            a_q;
  logic                       wr_vld_q;
  logic [ppgb_pkg::ColW-1:0]  wr_addr_q;
  logic [ppgb_pkg::SizeW-1:0] wr_val_q;
  logic [ppgb_pkg::SizeW-1:0] base_cnt;
  logic [ppgb_pkg::SizeW-1:0] new_cnt;

  // scan stage
  logic [ppgb_pkg::SizeW-1:0] scan_cnt_q, scan_cnt_d;
  logic                       s_vld_q;
  logic [ppgb_pkg::ColW-1:0]  s_idx_q;
  logic                       scan_issue;
  logic                       col_good;
  logic [ppgb_pkg::ColW-1:0]  col_first_q, col_first_d;
  logic [ppgb_pkg::ColW-1:0]  col_last_q, col_last_d;
  logic                       col_any_q, col_any_d;

  // row results of the frame under scan
  logic [ppgb_pkg::RowW-1:0]  top_row_q;
  logic [ppgb_pkg::RowW-1:0]  row_span_q;
  logic                       rows_found_q;

  logic                       out_vld_q, out_vld_d;
  logic                       out_load;
  logic [ppgb_pkg::SizeW-1:0] w;
  logic                       pop;
  logic                       rd_en;
  logic [ppgb_pkg::ColW-1:0]  rd_addr;

  logic [ppgb_pkg::ColW-1:0]  left_col_q;
  logic [ppgb_pkg::ColW-1:0]  col_span_q;
  logic [ppgb_pkg::RowW-1:0]  out_top_q;
  logic [ppgb_pkg::RowW-1:0]  out_span_q;
  logic                       out_cols_q;
  logic                       out_rows_q;

  assign w = ppgb_pkg::clamp_size(width_i, ppgb_pkg::SizeW'(ppgb_pkg::MaxWidth));

  assign pop         = pop_valid_i && (state_q == StRun) && !eof_pend_q;
  assign pop_ready_o = pop;

  assign scan_issue = (state_q == StScan) && (scan_cnt_q < w);
  assign rd_en      = pop || scan_issue;
  assign rd_addr    = (state_q == StScan) ? scan_cnt_q[ppgb_pkg::ColW-1:0] : pop_data_i.x;

  // the write of the previous cycle is not yet visible in rdata_q
  always_comb begin
    if (a_q.first_row) begin
      base_cnt = '0;
    end else if (wr_vld_q && (wr_addr_q == a_q.x)) begin
      base_cnt = wr_val_q;
    end else begin
      base_cnt = rdata_q;
    end
  end
  assign new_cnt = base_cnt + ppgb_pkg::SizeW'(a_q.dark);

  always_ff @(posedge clk_i) begin
    if (a_vld_q) begin
      col_mem[a_q.x] <= new_cnt;
    end
    if (rd_en) begin
      rdata_q <= col_mem[rd_addr];
    end
  end

  assign col_good = s_vld_q && ppgb_pkg::over_threshold(rdata_q, w);

  always_comb begin
    col_first_d = col_first_q;
    col_last_d  = col_last_q;
    col_any_d   = col_any_q;
    if (col_good) begin
      if (!col_any_q) begin
        col_first_d = s_idx_q;
      end
      col_last_d = s_idx_q;
      col_any_d  = 1'b1;
    end
    if (a_vld_q && a_q.frame_end) begin
      col_first_d = '0;
      col_last_d  = '0;
      col_any_d   = 1'b0;
    end
  end

  assign out_load = (state_q == StDone) && (!out_vld_q || result_o.ready);

  always_comb begin
    state_d    = state_q;
    eof_pend_d = eof_pend_q;
    scan_cnt_d = scan_cnt_q;
    if (pop && pop_data_i.frame_end) begin
      eof_pend_d = 1'b1;
    end
    case (state_q)
      StRun: begin
        if (a_vld_q && a_q.frame_end) begin
          state_d    = StScan;
          scan_cnt_d = '0;
        end
      end
      StScan: begin
        if (scan_issue) begin
          scan_cnt_d = scan_cnt_q + ppgb_pkg::SizeW'(1);
        end else if (!s_vld_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          state_d    = StRun;
          eof_pend_d = 1'b0;
        end
      end
      default: begin
        state_d = StRun;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && result_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StRun;
      eof_pend_q <= 1'b0;
      a_vld_q    <= 1'b0;
      wr_vld_q   <= 1'b0;
      s_vld_q    <= 1'b0;
      scan_cnt_q <= '0;
      col_any_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      eof_pend_q <= eof_pend_d;
      a_vld_q    <= pop;
      wr_vld_q   <= a_vld_q;
      s_vld_q    <= scan_issue;
      scan_cnt_q <= scan_cnt_d;
      col_any_q  <= col_any_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      a_q <= pop_data_i;
    end
    wr_addr_q   <= a_q.x;
    wr_val_q    <= new_cnt;
    s_idx_q     <= scan_cnt_q[ppgb_pkg::ColW-1:0];
    col_first_q <= col_first_d;
    col_last_q  <= col_last_d;
    if (a_vld_q && a_q.frame_end) begin
      top_row_q    <= a_q.top_row;
      row_span_q   <= a_q.row_span;
      rows_found_q <= a_q.rows_found;
    end
    if (out_load) begin
      left_col_q <= col_any_q ? col_first_q : '0;
      col_span_q <= col_any_q ? (col_last_q - col_first_q) : '0;
      out_top_q  <= top_row_q;
      out_span_q <= row_span_q;
      out_cols_q <= col_any_q;
      out_rows_q <= rows_found_q;
    end
  end

  assign result_o.valid      = out_vld_q;
  assign result_o.left_col   = left_col_q;
  assign result_o.col_span   = col_span_q;
  assign result_o.top_row    = out_top_q;
  assign result_o.row_span   = out_span_q;
  assign result_o.cols_found = out_cols_q;
  assign result_o.rows_found = out_rows_q;

endmodule

/* hw/rtl/projection_profile_grid_bounds_top.sv */
// projection profile bounds: apb registers, front end, queue and back end
// throughput: one pixel per cycle inside a frame while the queue has room; after the last pixel of a frame
//   input stalls once the four entry queue has filled, until the frame result is loaded
// column scan after the last pixel of a frame: one column store read per cycle
// reset: asynchronous active low, clears positions, profiles and handshakes;
//   width and height registers reset to 1024, column store needs no clearing
`timescale 1ns / 1ps

module projection_profile_grid_bounds_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppgb_pixel_if.sink  pixel_i,
  ppgb_result_if.source result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers, word addressed, low address bits ignored
  logic [ppgb_pkg::SizeW-1:0] width_q;
  logic [ppgb_pkg::SizeW-1:0] height_q;
  logic                       cfg_write;
  logic                       reg_sel;

  // transfer between front end and queue
  logic            push_valid;
  logic            push_ready;
  ppgb_pkg::work_t push_data;

  // transfer between queue and back end
  logic            pop_valid;
  logic            pop_ready;
  ppgb_pkg::work_t pop_data;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ppgb_pkg::SizeW'(ppgb_pkg::MaxWidth);
      height_q <= ppgb_pkg::SizeW'(ppgb_pkg::MaxHeight);
    end else if (cfg_write) begin
      if (reg_sel == ppgb_pkg::RegWidth) begin
        width_q <= pwdata[ppgb_pkg::SizeW-1:0];
      end else begin
        height_q <= pwdata[ppgb_pkg::SizeW-1:0];
      end
    end
  end

  // read back the raw register value
  assign prdata = (reg_sel == ppgb_pkg::RegHeight) ? 32'(height_q) : 32'(width_q);

  // front end: dark test, raster position, row profile
  ppgb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .width_i      (width_q),
    .height_i     (height_q),
    .pixel_i      (pixel_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // decouples pixel intake from column store updates and the frame end scan
  ppgb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // back end: column counts read-modify-write, column scan, result register
  ppgb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .width_i     (width_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .result_o    (result_o)
  );

endmodule

/* tb/tb.sv */
// self-checking testbench for projection_profile_grid_bounds_top: frame bounds predictor
`timescale 1ns / 1ps

module tb;
  import ppgb_pkg::*;

  // one frame result as it appears on the result channel
  typedef struct packed {
    logic [9:0] left_col;
    logic [9:0] col_span;
    logic [9:0] top_row;
    logic [9:0] row_span;
    logic       cols_found;
    logic       rows_found;
  } box_t;

  // predicts the bounding box of every frame from the accepted pixels
  class frame_bounds_checker;
    bit [SizeW-1:0] width_reg;
    bit [SizeW-1:0] height_reg;
    bit [SizeW-1:0] col_count [MaxWidth];
    bit [SizeW-1:0] row_count;
    bit [ColW-1:0]  x_pos;
    bit [RowW-1:0]  y_pos;
    bit [RowW-1:0]  first_row;
    bit [RowW-1:0]  last_row;
    bit             any_row;
    box_t           expected_boxes[$];
    int             errors;
    int             frames_done;

    function new();
      width_reg   = SizeW'(MaxWidth);
      height_reg  = SizeW'(MaxHeight);
      row_count   = '0;
      x_pos       = '0;
      y_pos       = '0;
      first_row   = '0;
      last_row    = '0;
      any_row     = 1'b0;
      errors      = 0;
      frames_done = 0;
    endfunction

    // 0 acts as 1, anything past the maximum acts as the maximum
    static function int unsigned fit_dim(bit [SizeW-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return 32'(v);
    endfunction

    function void set_size(logic idx, logic [31:0] data);
      if (idx == RegWidth) width_reg = data[SizeW-1:0];
      else height_reg = data[SizeW-1:0];
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned first_col;
      int unsigned last_col;
      bit          any_col;
      bit          dark;
      box_t        box;
      w = fit_dim(width_reg, MaxWidth);
      h = fit_dim(height_reg, MaxHeight);
      dark = (int'(r) + int'(g) + int'(b)) < DarkLimit;
      if (y_pos == 0) col_count[x_pos] = SizeW'(dark);
      else col_count[x_pos] = col_count[x_pos] + SizeW'(dark);
      row_count = row_count + SizeW'(dark);
      if (int'(x_pos) + 1 < w) begin
        x_pos = x_pos + ColW'(1);
        return;
      end
      // row done, rows are judged against the height
      if (5 * int'(row_count) > 2 * h) begin
        if (!any_row) first_row = y_pos;
        last_row = y_pos;
        any_row  = 1'b1;
      end
      row_count = '0;
      x_pos     = '0;
      if (int'(y_pos) + 1 < h) begin
        y_pos = y_pos + RowW'(1);
        return;
      end
      // frame done, columns are judged against the width
      first_col = 0;
      last_col  = 0;
      any_col   = 1'b0;
      for (c = 0; c < w; c++) begin
        if (5 * int'(col_count[c]) > 2 * w) begin
          if (!any_col) first_col = c;
          last_col = c;
          any_col  = 1'b1;
        end
      end
      box.left_col   = any_col ? 10'(first_col) : '0;
      box.col_span   = any_col ? 10'(last_col - first_col) : '0;
      box.top_row    = any_row ? first_row : '0;
      box.row_span   = any_row ? 10'(last_row - first_row) : '0;
      box.cols_found = any_col;
      box.rows_found = any_row;
      expected_boxes.push_back(box);
      y_pos     = '0;
      first_row = '0;
      last_row  = '0;
      any_row   = 1'b0;
    endfunction

    function void check_result(box_t got);
      box_t want;
      if (expected_boxes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb: result with no frame pending: left=%0d span=%0d top=%0d span=%0d cf=%0b rf=%0b",
                   got.left_col, got.col_span, got.top_row, got.row_span,
                   got.cols_found, got.rows_found);
        return;
      end
      want = expected_boxes.pop_front();
      if (got.left_col !== want.left_col || got.col_span !== want.col_span ||
          got.top_row !== want.top_row || got.row_span !== want.row_span ||
          got.cols_found !== want.cols_found || got.rows_found !== want.rows_found) begin
        errors++;
        if (errors <= 10) begin
          $display("tb: frame %0d mismatch", frames_done);
          $display("  expected left=%0d span=%0d top=%0d span=%0d cf=%0b rf=%0b",
                   want.left_col, want.col_span, want.top_row, want.row_span,
                   want.cols_found, want.rows_found);
          $display("  actual   left=%0d span=%0d top=%0d span=%0d cf=%0b rf=%0b",
                   got.left_col, got.col_span, got.top_row, got.row_span,
                   got.cols_found, got.rows_found);
        end
      end
      frames_done++;
    endfunction

    function void check_drained();
      if (expected_boxes.size() != 0) begin
        errors++;
        if (errors <= 10)
          $display("tb: %0d frame results never arrived", expected_boxes.size());
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ppgb_pixel_if  pix ();
  ppgb_result_if res ();

  projection_profile_grid_bounds_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pixel_i  (pix),
    .result_o (res),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk_i = ~clk_i;

  frame_bounds_checker bounds = new();

  // frame size as the block sees it, after clamping
  int unsigned cur_w = MaxWidth;
  int unsigned cur_h = MaxHeight;
  int          pixels_sent = 0;
  bit          send_idle = 1'b1;
  bit          rcv_idle = 1'b1;
  // long receiver hold-off, picked up by the result process after its next transfer
  int          hold_cycles = 0;

  // one pixel transfer; valid stays high across back-to-back pixels
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = send_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    do @(posedge clk_i); while (!pix.ready);
    // transfer happened at this edge
    bounds.note_pixel(r, g, b);
    pixels_sent++;
  endtask

  // random colors on the requested side of the dark limit
  task automatic send_shade(bit dark);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    do begin
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
    end while (((int'(r) + int'(g) + int'(b)) < DarkLimit) != dark);
    send_pixel(r, g, b);
  endtask

  // a frame with a dark box on a sparse background, or a flat or noisy frame
  task automatic send_frame(int unsigned w, int unsigned h);
    int unsigned x0;
    int unsigned x1;
    int unsigned y0;
    int unsigned y1;
    int unsigned x;
    int unsigned y;
    int unsigned style;
    bit          dark;
    bit          in_box;
    style = $urandom_range(0, 9);
    x0 = $urandom_range(0, w - 1);
    x1 = $urandom_range(x0, w - 1);
    y0 = $urandom_range(0, h - 1);
    y1 = $urandom_range(y0, h - 1);
    for (y = 0; y < h; y++) begin
      for (x = 0; x < w; x++) begin
        in_box = (x >= x0) && (x <= x1) && (y >= y0) && (y <= y1);
        case (style)
          0: begin
            dark = 1'b0;
          end
          1: begin
            dark = 1'b1;
          end
          2, 3: begin
            dark = 1'($urandom_range(0, 1));
          end
          default: begin
            dark = in_box ? ($urandom_range(0, 99) < 90) : ($urandom_range(0, 99) < 8);
          end
        endcase
        send_shade(dark);
      end
    end
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(logic idx, logic [SizeW-1:0] value);
    logic [31:0] data;
    data = $urandom;
    data[SizeW-1:0] = value;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    bounds.set_size(idx, data);
  endtask

  // stop offering pixels, let every result arrive, then give the scan time to finish
  task automatic wait_idle();
    pix.valid <= 1'b0;
    do @(posedge clk_i); while (bounds.expected_boxes.size() != 0);
    repeat (cur_w + 20) @(posedge clk_i);
  endtask

  task automatic set_dims(logic [SizeW-1:0] w, logic [SizeW-1:0] h);
    wait_idle();
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    cur_w = frame_bounds_checker::fit_dim(w, MaxWidth);
    cur_h = frame_bounds_checker::fit_dim(h, MaxHeight);
  endtask

  // result side: random ready gaps per transfer, plus the occasional long hold
  initial begin
    int gap;
    res.ready = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        res.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      gap = rcv_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (!res.valid);
      bounds.check_result({res.left_col, res.col_span, res.top_row, res.row_span,
                           res.cols_found, res.rows_found});
    end
  end

  initial begin
    int unsigned w_val;
    int unsigned h_val;
    pix.valid = 1'b0;
    pix.red   = '0;
    pix.green = '0;
    pix.blue  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // dark limit edges: black, white, sum just under and exactly at the limit
    set_dims(4, 2);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd244, 8'd0);
    send_pixel(8'd255, 8'd245, 8'd0);
    repeat (4) send_shade(1'b1);

    // zero sizes act as one: single pixel frames, one dark and one light
    set_dims(0, 0);
    send_shade(1'b1);
    send_shade(1'b0);

    // single column frame
    set_dims(1, 3);
    send_shade(1'b1);
    send_shade(1'b0);
    send_shade(1'b1);

    // size shrinks mid-frame: width and height drop while the second row is under way
    set_dims(4, 3);
    repeat (6) send_shade(1'($urandom_range(0, 1)));
    wait_idle();
    write_reg(RegWidth, 2);
    write_reg(RegHeight, 2);
    cur_w = 2;
    cur_h = 2;
    send_shade(1'b1);

    // oversized registers clamp to the maximum, then shrink before the first row ends
    set_dims(11'h7FF, 11'h7FF);
    repeat (5) send_shade(1'($urandom_range(0, 1)));
    wait_idle();
    write_reg(RegWidth, 3);
    write_reg(RegHeight, 1);
    cur_w = 3;
    cur_h = 1;
    send_shade(1'b1);

    // back pressure: tiny frames while the result side holds off
    set_dims(1, 1);
    send_idle   = 1'b0;
    hold_cycles = 400;
    repeat (40) send_shade(1'($urandom_range(0, 1)));

    // random phases, mostly small frames
    while (pixels_sent < 750) begin
      w_val = $urandom_range(0, 19);
      w_val = (w_val == 0) ? 0 : (w_val < 16) ? $urandom_range(1, 8) : $urandom_range(9, 32);
      h_val = $urandom_range(0, 19);
      h_val = (h_val == 0) ? 0 : (h_val < 16) ? $urandom_range(1, 8) : $urandom_range(9, 32);
      set_dims(SizeW'(w_val), SizeW'(h_val));
      send_idle = ($urandom_range(0, 3) != 0);
      rcv_idle  = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4)) send_frame(cur_w, cur_h);
    end

    wait_idle();
    bounds.check_drained();
    if (bounds.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
